// File: src/bitmap_run_slot_allocator_assert.svh
// assertion macros for the slot allocator
`ifndef BITMAP_RUN_SLOT_ALLOCATOR_ASSERT_SVH
`define BITMAP_RUN_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BRSA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slot allocator check failed");

// next-cycle implication, checked out of reset
`define BRSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slot allocator check failed");

`endif

// File: src/brsa_pkg.sv
// shared types and codes of the slot allocator
package brsa_pkg;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_ROOM     = 2'd1,
        ST_DOUBLE_FREE = 2'd2,
        ST_BAD         = 2'd3
    } t_status;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam int CountWidth = 10;
    localparam int StartWidth = 9;
    localparam int LongestMax = 1023;

endpackage

// File: src/bitmap_run_slot_allocator.sv
// first-fit run allocator over a rotating slot bitmap
// a new word is taken only while idle, after the previous word has been finished;
// the bitmap rotates one bit per cycle in scan and mark:
// one full turn for the fit or double-free search, one turn to mark and measure runs
// a finished result waits in the output register while the next word is taken
// reset clears the whole bitmap (all slots free) and the control state
module bitmap_run_slot_allocator #(
    parameter int SLOTS = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_operation,
    input  logic [brsa_pkg::CountWidth-1:0]     i_slot_count,
    input  logic [brsa_pkg::StartWidth-1:0]     i_start_slot,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output brsa_pkg::t_status                   o_status,
    output logic [brsa_pkg::StartWidth-1:0]     o_run_start,
    output logic [brsa_pkg::CountWidth-1:0]     o_longest_free_run,
    output logic                                o_page_empty
);
    import brsa_pkg::*;

    `include "bitmap_run_slot_allocator_assert.svh"

    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = (CW > CountWidth + 1) ? CW : CountWidth + 1;
    localparam logic [SW-1:0] SLOTS_W = SW'(SLOTS);
    localparam logic [CW-1:0] LAST = CW'(SLOTS - 1);
    localparam logic [CountWidth-1:0] LR_FULL =
        (SLOTS > LongestMax) ? CountWidth'(LongestMax) : CountWidth'(SLOTS);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_MARK, S_FINISH} t_state;

    t_state                 r_state;
    logic [SLOTS-1:0]       r_map;
    logic [CW-1:0]          r_idx;
    logic                   r_op;
    logic [CountWidth-1:0]  r_count;
    logic [SW-1:0]          r_lo;
    logic [SW-1:0]          r_hi;
    logic                   r_bad;
    logic                   r_found;
    logic                   r_dbl;
    logic                   r_modify;
    logic [CW-1:0]          r_cur;
    logic [CW-1:0]          r_best;
    logic                   r_any;
    t_status                r_status;
    logic [StartWidth-1:0]  r_run_start;
    logic                   r_out_valid;
    t_status                r_o_status;
    logic [StartWidth-1:0]  r_o_run_start;
    logic [CountWidth-1:0]  r_o_longest;
    logic                   r_o_empty;

    logic                   bit_now;
    logic [SW-1:0]          idx_w;
    logic                   in_rng;
    logic [CW-1:0]          cur_scan;
    logic                   n_bit;
    logic [CW-1:0]          n_cur;
    logic [SW-1:0]          n_end;
    logic                   n_bad;
    logic                   fit_hit;

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_status           = r_o_status;
    assign o_run_start        = r_o_run_start;
    assign o_longest_free_run = r_o_longest;
    assign o_page_empty       = r_o_empty;

    always_comb begin
        bit_now  = r_map[0];
        idx_w    = SW'(r_idx);
        in_rng   = (idx_w >= r_lo) && (idx_w < r_hi);
        cur_scan = bit_now ? '0 : r_cur + 1'b1;
        fit_hit  = !r_found && !bit_now && (SW'(cur_scan) == SW'(r_count));
        n_bit    = (r_modify && in_rng) ? (r_op == OP_ALLOC) : bit_now;
        n_cur    = n_bit ? '0 : r_cur + 1'b1;
        n_end    = SW'(i_start_slot) + SW'(i_slot_count);
        if (i_slot_count == '0) begin
            n_bad = 1'b1;
        end else if (i_operation == OP_ALLOC) begin
            n_bad = SW'(i_slot_count) > SLOTS_W;
        end else begin
            n_bad = n_end > SLOTS_W;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_map       <= '0;
            r_out_valid <= 1'b0;
            r_modify    <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op     <= i_operation;
                        r_count  <= i_slot_count;
                        r_lo     <= SW'(i_start_slot);
                        r_hi     <= n_end;
                        r_bad    <= n_bad;
                        r_found  <= 1'b0;
                        r_dbl    <= 1'b0;
                        r_modify <= 1'b0;
                        r_cur    <= '0;
                        r_idx    <= '0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_map <= {bit_now, r_map[SLOTS-1:1]};
                    r_cur <= cur_scan;
                    if (r_op == OP_ALLOC) begin
                        if (fit_hit) begin
                            r_found <= 1'b1;
                            r_lo    <= idx_w + 1'b1 - SW'(r_count);
                            r_hi    <= idx_w + 1'b1;
                        end
                    end else if (in_rng && !bit_now) begin
                        r_dbl <= 1'b1;
                    end
                    if (r_idx == LAST) begin
                        // decide the outcome once the whole map has gone by
                        r_run_start <= '0;
                        r_modify    <= 1'b0;
                        if (r_bad) begin
                            r_status <= ST_BAD;
                        end else if (r_op == OP_ALLOC) begin
                            if (r_found || fit_hit) begin
                                r_status    <= ST_OK;
                                r_modify    <= 1'b1;
                                r_run_start <= fit_hit
                                    ? StartWidth'(idx_w + 1'b1 - SW'(r_count))
                                    : StartWidth'(r_lo);
                            end else begin
                                r_status <= ST_NO_ROOM;
                            end
                        end else if (r_dbl || (in_rng && !bit_now)) begin
                            r_status <= ST_DOUBLE_FREE;
                        end else begin
                            r_status <= ST_OK;
                            r_modify <= 1'b1;
                        end
                        r_idx   <= '0;
                        r_cur   <= '0;
                        r_best  <= '0;
                        r_any   <= 1'b0;
                        r_state <= S_MARK;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_MARK: begin
                    // write back the marked bit and measure runs on the new map
                    r_map <= {n_bit, r_map[SLOTS-1:1]};
                    r_cur <= n_cur;
                    if (n_cur > r_best) begin
                        r_best <= n_cur;
                    end
                    if (n_bit) begin
                        r_any <= 1'b1;
                    end
                    if (r_idx == LAST) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid   <= 1'b1;
                        r_o_status    <= r_status;
                        r_o_run_start <= r_run_start;
                        r_o_longest   <= (SW'(r_best) > SW'(LongestMax))
                            ? CountWidth'(LongestMax) : CountWidth'(r_best);
                        r_o_empty     <= !r_any;
                        r_modify      <= 1'b0;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `BRSA_ASSERT_NOW(a_start_only_on_ok, o_out_valid && (o_run_start != '0), o_status == ST_OK)
    `BRSA_ASSERT_NOW(a_empty_full_run, o_out_valid && o_page_empty, o_longest_free_run == LR_FULL)
    `BRSA_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)
    `BRSA_ASSERT_NOW(a_mark_in_page, (r_state == S_MARK) && r_modify, r_hi <= SLOTS_W)

endmodule
